/* rtl/mpr_pkg.sv */
// Package for the multi-pattern replace block: input kinds, sequencer states,
// table size limits and register indexes.
// No dependencies.
package mpr_pkg;

  localparam int unsigned MAX_PATTERNS    = 8;
  localparam int unsigned MAX_PATTERN_LEN = 8;
  localparam int unsigned MAX_REPLACE_LEN = 8;

  typedef enum logic [1:0] {
    KIND_PAT  = 2'd0,
    KIND_REP  = 2'd1,
    KIND_TEXT = 2'd2,
    KIND_DRAIN = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_CMP,
    ST_EMIT,
    ST_OUT
  } state_t;

  localparam int unsigned CFG_PCOUNT = 0;
  localparam int unsigned CFG_RCOUNT = 1;

endpackage

/* rtl/mpr_core.sv */
// Sequencer and datapath of the multi-pattern replace block: pattern and
// replacement memories, lookahead window and one shared byte comparator.
// Depends on mpr_pkg.
module mpr_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] kind,
  input  logic [2:0] slot,
  input  logic [2:0] position,
  input  logic [3:0] entry_length,
  input  logic [7:0] data_byte,
  input  logic [3:0] pattern_count,
  input  logic [3:0] replacement_count,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       last_of_run,
  output logic       window_empty
);
  import mpr_pkg::*;

  localparam int PW = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
  localparam int LW = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
  localparam int RW = (MAX_REPLACE_LEN > 1) ? $clog2(MAX_REPLACE_LEN) : 1;
  localparam int FW = $clog2(MAX_PATTERN_LEN + 1);
  localparam int CW = 8;

  logic [7:0] pmem [MAX_PATTERNS*MAX_PATTERN_LEN];
  logic [7:0] rmem [MAX_PATTERNS*MAX_REPLACE_LEN];
  logic [7:0] win  [MAX_PATTERN_LEN];
  logic [CW-1:0] plen [MAX_PATTERNS];
  logic [CW-1:0] rlen [MAX_PATTERNS];

  state_t state, state_next;
  logic [FW-1:0] fill;
  logic [LW-1:0] head;
  logic [PW:0]   pidx;
  logic [CW-1:0] bidx;
  logic [CW-1:0] skip;
  logic          found;
  logic [7:0]    obyte;
  logic          ovalid, olast, oempty;

  logic [CW-1:0] used;
  logic          acc;
  logic [CW-1:0] cur_len;
  logic [7:0]    pbyte, wbyte, rbyte;
  logic          pat_ok, rep_ok;
  logic [CW-1:0] fill_w;

  // The window advances on the emit cycle of the final result item.
  function automatic logic olast_next_is_done();
    logic r;
    r = !found || !(CW'(pidx) < CW'(replacement_count) && rlen[pidx[PW-1:0]] != '0)
      || (bidx + 1'b1 == rlen[pidx[PW-1:0]]);
    return r;
  endfunction

  assign in_ready  = (state == ST_IDLE);
  assign acc       = in_valid && in_ready;
  assign fill_w    = CW'(fill);
  assign used      = (CW'(pattern_count) > CW'(MAX_PATTERNS)) ? CW'(MAX_PATTERNS)
                   : CW'(pattern_count);

  assign pat_ok = (32'(slot) < MAX_PATTERNS) && (32'(position) < MAX_PATTERN_LEN)
               && (32'(entry_length) <= MAX_PATTERN_LEN);
  assign rep_ok = (32'(slot) < MAX_PATTERNS) && (32'(position) < MAX_REPLACE_LEN)
               && (32'(entry_length) <= MAX_REPLACE_LEN);

  // One comparator: the registered pattern byte against the window byte.
  always_comb begin
    cur_len = plen[pidx[PW-1:0]];
    wbyte   = win[LW'((32'(head) + 32'(bidx)) % MAX_PATTERN_LEN)];
  end

  // Memory reads are registered; the fetch state waits for them.
  always_ff @(posedge clk) begin
    if (acc && kind == KIND_PAT && pat_ok)
      pmem[{slot[PW-1:0], position[LW-1:0]}] <= data_byte;
    if (acc && kind == KIND_REP && rep_ok)
      rmem[{slot[PW-1:0], position[RW-1:0]}] <= data_byte;
    if (acc && kind == KIND_TEXT && 32'(fill) < MAX_PATTERN_LEN)
      win[LW'((32'(head) + 32'(fill)) % MAX_PATTERN_LEN)] <= data_byte;
    pbyte <= pmem[{pidx[PW-1:0], bidx[LW-1:0]}];
    rbyte <= rmem[{pidx[PW-1:0], bidx[RW-1:0]}];
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (acc && (kind == KIND_DRAIN ||
            (kind == KIND_TEXT && 32'(fill) + 1 == MAX_PATTERN_LEN)))
          state_next = ST_FETCH;
      end
      ST_FETCH: begin
        if (fill == '0 || found || CW'(pidx) >= used) state_next = ST_EMIT;
        else state_next = ST_CMP;
      end
      ST_CMP: state_next = ST_FETCH;
      ST_EMIT: state_next = ST_OUT;
      ST_OUT: begin
        if (out_ready) state_next = olast ? ST_IDLE : ST_EMIT;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill  <= '0;
      head  <= '0;
      for (int i = 0; i < MAX_PATTERNS; i++) begin
        plen[i] <= '0;
        rlen[i] <= '0;
      end
      pidx <= '0; bidx <= '0; found <= 1'b0; skip <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          pidx <= '0; bidx <= '0; found <= 1'b0; skip <= CW'(1);
          if (acc && kind == KIND_PAT && pat_ok) plen[slot[PW-1:0]] <= CW'(entry_length);
          if (acc && kind == KIND_REP && rep_ok) rlen[slot[PW-1:0]] <= CW'(entry_length);
          if (acc && kind == KIND_TEXT && 32'(fill) < MAX_PATTERN_LEN)
            fill <= fill + FW'(1);
        end
        ST_FETCH: ;
        ST_CMP: begin
          // One byte compare per visit; skip patterns that cannot fit.
          if (fill != '0 && !found && CW'(pidx) < used) begin
            if (cur_len == '0 || cur_len > fill_w || pbyte != wbyte) begin
              pidx <= pidx + 1'b1; bidx <= '0;
            end else if (bidx + 1'b1 == cur_len) begin
              found <= 1'b1; skip <= cur_len; bidx <= '0;
            end else begin
              bidx <= bidx + 1'b1;
            end
          end
        end
        ST_EMIT: begin
          if (fill == '0) begin
            obyte <= '0; ovalid <= 1'b0; olast <= 1'b1;
          end else if (!found) begin
            obyte <= wbyte; ovalid <= 1'b1; olast <= 1'b1;
          end else if (CW'(pidx) < CW'(replacement_count) && rlen[pidx[PW-1:0]] != '0) begin
            obyte <= rbyte; ovalid <= 1'b1;
            olast <= (bidx + 1'b1 == rlen[pidx[PW-1:0]]);
            bidx <= bidx + 1'b1;
          end else begin
            obyte <= '0; ovalid <= 1'b0; olast <= 1'b1;
          end
          // Every item of a decision reports whether the window is empty after the decision.
          oempty <= (fill == '0) || (fill_w == skip);
          if (fill != '0 && (olast_next_is_done())) begin
            head <= LW'((32'(head) + 32'(skip)) % MAX_PATTERN_LEN);
            fill <= FW'(fill_w - skip);
          end
        end
        ST_OUT: ;
        default: ;
      endcase
    end
  end

  // Output signals.
  always_comb begin
    out_valid    = (state == ST_OUT);
    out_byte     = obyte;
    byte_valid   = ovalid;
    last_of_run  = olast;
    window_empty = oempty;
  end

  a_fill: assert property (@(posedge clk) disable iff (rst)
    32'(fill) <= MAX_PATTERN_LEN) else $error("window fill overflow");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken during output");
  a_del: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !byte_valid) |-> last_of_run) else $error("empty item not last");
endmodule

/* rtl/multi_pattern_replace.sv */
// Channel  | direction | tdata / tuser contents
// s_axis   | in        | tuser: kind[1:0]; tdata: slot[2:0] position[5:3]
//          |           |        entry_length[9:6] data_byte[17:10]
// m_axis   | out       | tdata: out_byte[7:0] window_empty[8]; tuser: byte_valid; tlast
// apb      | cfg       | 0x0 pattern_count, 0x4 replacement_count
// Loads and text bytes that leave the window short are taken in idle and start no decision.
// A decision runs a fetch state, then a compare and a fetch state for each
// pattern byte checked or pattern passed over on the single shared comparator,
// then an emit and an output state per result item; output holds while it stalls.
// Reset is synchronous; the input is not ready until the last result transfer.
// Depends on mpr_pkg and mpr_core.
module multi_pattern_replace (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // slot, position, entry_length, data_byte
  input  logic [1:0]  s_axis_tuser,  // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // out_byte, window_empty
  output logic        m_axis_tuser,  // byte_valid
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mpr_pkg::*;

  logic [3:0] pattern_count, replacement_count;
  logic [7:0] out_byte;
  logic       window_empty;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_count <= '0;
      replacement_count <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        1'(CFG_PCOUNT): pattern_count <= pwdata[3:0];
        1'(CFG_RCOUNT): replacement_count <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      1'(CFG_PCOUNT): prdata = {28'd0, pattern_count};
      1'(CFG_RCOUNT): prdata = {28'd0, replacement_count};
      default: ;
    endcase
  end

  mpr_core u_core (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .kind(s_axis_tuser), .slot(s_axis_tdata[2:0]),
    .position(s_axis_tdata[5:3]), .entry_length(s_axis_tdata[9:6]),
    .data_byte(s_axis_tdata[17:10]),
    .pattern_count, .replacement_count,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_byte, .byte_valid(m_axis_tuser), .last_of_run(m_axis_tlast), .window_empty
  );

  assign m_axis_tdata = {7'd0, window_empty, out_byte};
endmodule
